// ===== rtl/tagged_shared_stack_top_assert.svh =====
// assertion macros for the tagged shared stack
// used by tagged_shared_stack_top, expects clk_i and rst_ni in scope
`ifndef TAGGED_SHARED_STACK_TOP_ASSERT_SVH
`define TAGGED_SHARED_STACK_TOP_ASSERT_SVH

// same-cycle implication
`define TSS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tss assertion failed");

// next-cycle implication
`define TSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tss assertion failed");

`endif

// ===== rtl/tss_pkg.sv =====
// package for the tagged shared stack: sizes, codes, item and row control types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tss_pkg;

  localparam int STACK_DEPTH   = 64;
  localparam int TAG_COUNT     = 16;
  localparam int PAYLOAD_WIDTH = 32;

  localparam int IDX_W  = $clog2(STACK_DEPTH);
  localparam int FILL_W = $clog2(STACK_DEPTH + 1);
  localparam int TAG_W  = (TAG_COUNT > 1) ? $clog2(TAG_COUNT) : 1;
  localparam int CNT_W  = $clog2(TAG_COUNT + 1);

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_CHECK  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_TAG  = 2'd1,
    ST_FULL     = 2'd2,
    ST_NO_MATCH = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  tag_id;
    logic [31:0] payload;
    logic [5:0]  level;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data_out;
    logic [5:0]  slot;
    logic [15:0] pending_mask;
    logic [4:0]  pending_count;
  } out_item_t;

  // control broadcast from the sequencer to the cell row
  typedef struct packed {
    logic             load;
    logic [IDX_W-1:0] load_idx;
    logic             shift;
    logic             clear;
    logic             kill;
    logic             wr;
    logic [IDX_W-1:0] wr_idx;
    logic [TAG_W-1:0] wr_tag;
    logic [TAG_W-1:0] srch_tag;
  } row_ctrl_t;

  // view of the cell that holds the scan token
  typedef struct packed {
    logic             live;
    logic [TAG_W-1:0] tag;
    logic             match;
  } row_stat_t;

endpackage

`default_nettype wire

// ===== rtl/tss_in_if.sv =====
// input channel of the tagged shared stack: valid, ready and one input item
// depends on tss_pkg
`timescale 1ns / 1ps
`default_nettype none

interface tss_in_if import tss_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/tss_out_if.sv =====
// result channel of the tagged shared stack: valid, ready and one result item
// depends on tss_pkg
`timescale 1ns / 1ps
`default_nettype none

interface tss_out_if import tss_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/tss_cell.sv =====
// one buffer entry: tag, live bit and the scan token slot
// depends on tss_pkg
`timescale 1ns / 1ps
`default_nettype none

module tss_cell import tss_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire row_ctrl_t ctrl_i,
  input  wire logic      load_sel_i,
  input  wire logic      wr_sel_i,
  input  wire logic      above_i,
  output logic           here_o,
  output logic           live_o,
  output row_stat_t      stat_o
);

  logic             here_q, here_d;
  logic             live_q, live_d;
  logic [TAG_W-1:0] tag_q;

  always_comb begin
    if (load_sel_i) begin
      here_d = 1'b1;
    end else if (ctrl_i.clear) begin
      here_d = 1'b0;
    end else if (ctrl_i.shift) begin
      here_d = above_i;
    end else begin
      here_d = here_q;
    end
  end

  always_comb begin
    if (wr_sel_i) begin
      live_d = 1'b1;
    end else if (ctrl_i.kill && here_q) begin
      live_d = 1'b0;
    end else begin
      live_d = live_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      here_q <= 1'b0;
      live_q <= 1'b0;
    end else begin
      here_q <= here_d;
      live_q <= live_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_sel_i) begin
      tag_q <= ctrl_i.wr_tag;
    end
  end

  // zero unless this cell holds the token, so the row can or them together
  always_comb begin
    stat_o.live  = here_q && live_q;
    stat_o.tag   = stat_o.live ? tag_q : '0;
    stat_o.match = stat_o.live && (tag_q == ctrl_i.srch_tag);
  end

  assign here_o = here_q;
  assign live_o = live_q;

endmodule

`default_nettype wire

// ===== rtl/tss_cell_row.sv =====
// row of buffer cells; the scan token walks down one cell per cycle
// depends on tss_pkg and tss_cell
`timescale 1ns / 1ps
`default_nettype none

module tss_cell_row import tss_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire row_ctrl_t         ctrl_i,
  output row_stat_t              stat_o,
  output logic [STACK_DEPTH-1:0] live_o,
  output logic [STACK_DEPTH-1:0] tok_o
);

  logic [STACK_DEPTH-1:0] here;
  row_stat_t              cell_stat [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic above;
    if (i == STACK_DEPTH - 1) begin : g_top
      assign above = 1'b0;
    end else begin : g_mid
      assign above = here[i+1];
    end

    tss_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl_i),
      .load_sel_i (ctrl_i.load && (ctrl_i.load_idx == IDX_W'(i))),
      .wr_sel_i   (ctrl_i.wr && (ctrl_i.wr_idx == IDX_W'(i))),
      .above_i    (above),
      .here_o     (here[i]),
      .live_o     (live_o[i]),
      .stat_o     (cell_stat[i])
    );
  end

  // at most one cell holds the token, the rest report zero
  always_comb begin
    stat_o = '0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      stat_o = stat_o | cell_stat[i];
    end
  end

  assign tok_o = here;

endmodule

`default_nettype wire

// ===== rtl/tagged_shared_stack_top.sv =====
// flow: push, bad tag, full and empty buffer go from start to finish; check and failed
//   pop or lookup walk the entries from the fill level down (up to 64); found lookup adds
//   a payload read; found pop reads, then drops the fill level past free entries at the top
// throughput: one item at a time, ready again the cycle after the result is loaded; a
//   result not yet taken holds the next one in the finish state
// reset: asynchronous active low, all entries free and fill level zero at once
`timescale 1ns / 1ps
`default_nettype none

module tagged_shared_stack_top import tss_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tss_in_if.sink      in_i,
  tss_out_if.source   out_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_START  = 6'b000010,
    S_SCAN   = 6'b000100,
    S_READ   = 6'b001000,
    S_LOWER  = 6'b010000,
    S_FINISH = 6'b100000
  } state_e;

  state_e                   state_q, state_d;
  action_e                  act_q, act_d;
  logic [7:0]               tag_q, tag_d;
  logic [31:0]              pay_q, pay_d;
  logic [5:0]               lvl_q, lvl_d;
  logic [5:0]               skip_q, skip_d;
  logic [FILL_W-1:0]        fill_q, fill_d;
  logic [IDX_W-1:0]         pos_q, pos_d;
  logic [TAG_COUNT-1:0]     seen_q, seen_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  status_e                  res_status_q, res_status_d;
  logic [31:0]              res_data_q, res_data_d;
  logic [5:0]               res_slot_q, res_slot_d;
  logic                     out_valid_q, out_valid_d;
  out_item_t                out_item_q, out_item_d;

  logic [PAYLOAD_WIDTH-1:0] pay_mem_q [STACK_DEPTH];
  logic [PAYLOAD_WIDTH-1:0] rdata_q;
  logic                     mem_we, mem_re;

  row_ctrl_t                ctrl;
  row_stat_t                stat;
  logic [STACK_DEPTH-1:0]   live_vec;
  logic [STACK_DEPTH-1:0]   tok_vec;

  logic                     accept;
  logic                     tag_bad;
  logic                     full;
  logic                     push_ok;
  logic                     finish_ld;
  logic [FILL_W-1:0]        fill_dec;
  logic [IDX_W-1:0]         top_idx;
  logic [4:0]               cnt_out;

  tss_cell_row u_row (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .stat_o (stat),
    .live_o (live_vec),
    .tok_o  (tok_vec)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign tag_bad    = (tag_q >= 8'(TAG_COUNT));
  assign full       = (fill_q == FILL_W'(STACK_DEPTH));
  assign fill_dec   = fill_q - 1'b1;
  assign top_idx    = fill_dec[IDX_W-1:0];
  assign push_ok    = (state_q == S_START) && (act_q == ACT_PUSH) && !tag_bad && !full;
  assign finish_ld  = (state_q == S_FINISH) && (!out_valid_q || out_o.ready);
  assign cnt_out    = (cnt_q > CNT_W'(31)) ? 5'd31 : 5'(cnt_q);

  always_comb begin
    state_d      = state_q;
    act_d        = act_q;
    tag_d        = tag_q;
    pay_d        = pay_q;
    lvl_d        = lvl_q;
    skip_d       = skip_q;
    fill_d       = fill_q;
    pos_d        = pos_q;
    seen_d       = seen_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    res_slot_d   = res_slot_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;

    ctrl          = '0;
    ctrl.load_idx = top_idx;
    ctrl.wr_idx   = fill_q[IDX_W-1:0];
    ctrl.wr_tag   = tag_q[TAG_W-1:0];
    ctrl.srch_tag = tag_q[TAG_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          act_d   = action_e'(in_i.data.action);
          tag_d   = in_i.data.tag_id;
          pay_d   = in_i.data.payload;
          lvl_d   = in_i.data.level;
          state_d = S_START;
        end
      end

      S_START: begin
        res_status_d = ST_OK;
        res_data_d   = '0;
        res_slot_d   = '0;
        seen_d       = '0;
        cnt_d        = '0;
        state_d      = S_FINISH;
        if (act_q == ACT_CHECK) begin
          if (fill_q != '0) begin
            ctrl.load = 1'b1;
            pos_d     = top_idx;
            state_d   = S_SCAN;
          end
        end else if (tag_bad) begin
          res_status_d = ST_BAD_TAG;
        end else if (act_q == ACT_PUSH) begin
          if (full) begin
            res_status_d = ST_FULL;
          end else begin
            ctrl.wr    = 1'b1;
            mem_we     = 1'b1;
            res_slot_d = 6'(fill_q[IDX_W-1:0]);
            fill_d     = fill_q + 1'b1;
          end
        end else begin
          skip_d = (act_q == ACT_POP) ? 6'd0 : lvl_q;
          if (fill_q == '0) begin
            res_status_d = ST_NO_MATCH;
          end else begin
            ctrl.load = 1'b1;
            pos_d     = top_idx;
            state_d   = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (act_q == ACT_CHECK) begin
          if (stat.live) begin
            seen_d[stat.tag] = 1'b1;
            if (!seen_q[stat.tag]) begin
              cnt_d = cnt_q + 1'b1;
            end
          end
          if (pos_q == '0) begin
            ctrl.clear = 1'b1;
            state_d    = S_FINISH;
          end else begin
            ctrl.shift = 1'b1;
            pos_d      = pos_q - 1'b1;
          end
        end else if (stat.match && (skip_q == '0)) begin
          // found: pop frees the entry under the token
          mem_re     = 1'b1;
          ctrl.kill  = (act_q == ACT_POP);
          ctrl.clear = 1'b1;
          state_d    = S_READ;
        end else begin
          if (stat.match) begin
            skip_d = skip_q - 1'b1;
          end
          if (pos_q == '0) begin
            res_status_d = ST_NO_MATCH;
            ctrl.clear   = 1'b1;
            state_d      = S_FINISH;
          end else begin
            ctrl.shift = 1'b1;
            pos_d      = pos_q - 1'b1;
          end
        end
      end

      S_READ: begin
        res_data_d = 32'(rdata_q);
        state_d    = (act_q == ACT_POP) ? S_LOWER : S_FINISH;
      end

      S_LOWER: begin
        // drop the fill level past free entries at the top
        if ((fill_q == '0) || live_vec[top_idx]) begin
          state_d = S_FINISH;
        end else begin
          fill_d = fill_dec;
        end
      end

      S_FINISH: begin
        if (finish_ld) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (finish_ld) begin
      out_valid_d              = 1'b1;
      out_item_d.status        = res_status_q;
      out_item_d.data_out      = res_data_q;
      out_item_d.slot          = res_slot_q;
      out_item_d.pending_mask  = 16'(seen_q);
      out_item_d.pending_count = cnt_out;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    tag_q        <= tag_d;
    pay_q        <= pay_d;
    lvl_q        <= lvl_d;
    skip_q       <= skip_d;
    pos_q        <= pos_d;
    seen_q       <= seen_d;
    cnt_q        <= cnt_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    res_slot_q   <= res_slot_d;
    out_item_q   <= out_item_d;
  end

  // payload store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pay_mem_q[fill_q[IDX_W-1:0]] <= PAYLOAD_WIDTH'(pay_q);
    end
    if (mem_re) begin
      rdata_q <= pay_mem_q[pos_q];
    end
  end

`include "tagged_shared_stack_top_assert.svh"

  `TSS_ASSERT_IMPL(a_fill_range, 1'b1, fill_q <= FILL_W'(STACK_DEPTH))
  `TSS_ASSERT_IMPL(a_top_live, (state_q == S_IDLE) && (fill_q != '0), live_vec[top_idx])
  `TSS_ASSERT_IMPL(a_one_token, 1'b1, $onehot0(tok_vec))
  `TSS_ASSERT_NEXT(a_push_fill, push_ok, fill_q == $past(fill_q) + 1'b1)

endmodule

`default_nettype wire
